### rtl/core/kps_pkg.sv
package kps_pkg;

  localparam int unsigned SenseLines = 4;
  localparam int unsigned CodeW = 4;
  localparam int unsigned DriveW = 4;
  localparam int unsigned MapW = 64;
  localparam logic [MapW-1:0] MapReset = 64'hDFE0_B987_C654_A321;

  localparam int unsigned DebounceSamplesDef = 4;
  localparam int unsigned ScanLinesDef = 4;

  // two entries let the front run a full tick ahead of the back
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [DriveW-1:0]                 drive_pattern;
    logic [SenseLines-1:0]             press;
    logic [SenseLines-1:0][CodeW-1:0]  codes;
  } kps_entry_t;

endpackage

### rtl/core/kps_front.sv
module kps_front import kps_pkg::*; #(
  parameter int unsigned DEBOUNCE_SAMPLES = DebounceSamplesDef,
  parameter int unsigned SCAN_LINES = ScanLinesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       sense_levels_i,
  input  logic [MapW-1:0]  key_code_map_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output kps_entry_t       entry_o
);

  localparam int unsigned LineW = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
  localparam int unsigned HistW = DEBOUNCE_SAMPLES;

  logic [LineW-1:0] line_q, line_d;
  logic [HistW-1:0] hist_q [SCAN_LINES][SenseLines];
  logic             deb_q  [SCAN_LINES][SenseLines];
  logic [HistW-1:0] hist_new [SenseLines];
  logic             deb_new  [SenseLines];
  logic [2:0]       line_ext;
  logic [2:0]       next_ext;
  logic             accept;

  function automatic logic [DriveW-1:0] drive_bits(input logic [2:0] line);
    logic [DriveW-1:0] low;
    low = (line < 3'd4) ? (DriveW'(1) << line[1:0]) : '0;
    return ~low;
  endfunction

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign line_d   = (line_q == LineW'(SCAN_LINES - 1)) ? '0 : line_q + LineW'(1);
  assign line_ext = 3'(line_q);
  assign next_ext = 3'(line_d);

  always_comb begin
    entry_o.drive_pattern = drive_bits(next_ext);
    for (int s = 0; s < SenseLines; s++) begin
      hist_new[s] = {hist_q[line_q][s][HistW-2:0], sense_levels_i[s]};
      if (hist_new[s] == '0) begin
        deb_new[s] = 1'b0;
      end else if (hist_new[s] == '1) begin
        deb_new[s] = 1'b1;
      end else begin
        deb_new[s] = deb_q[line_q][s];
      end
      entry_o.press[s] = deb_q[line_q][s] && !deb_new[s];
      // map index wraps at sixteen keys
      entry_o.codes[s] = key_code_map_i[{line_ext[1:0], 2'(s)} * CodeW +: CodeW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      for (int l = 0; l < SCAN_LINES; l++) begin
        for (int s = 0; s < SenseLines; s++) begin
          hist_q[l][s] <= '1;
          deb_q[l][s]  <= 1'b1;
        end
      end
    end else if (accept) begin
      line_q <= line_d;
      for (int s = 0; s < SenseLines; s++) begin
        hist_q[line_q][s] <= hist_new[s];
        deb_q[line_q][s]  <= deb_new[s];
      end
    end
  end

endmodule

### rtl/core/kps_fifo.sv
module kps_fifo import kps_pkg::*; #(
  parameter int unsigned WIDTH = $bits(kps_entry_t)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/core/kps_back.sv
module kps_back import kps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  kps_entry_t        head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DriveW-1:0] drive_pattern_o,
  output logic              key_valid_o,
  output logic [CodeW-1:0]  key_code_o,
  output logic              last_in_run_o
);

  localparam int unsigned SelW = $clog2(SenseLines);

  logic [SenseLines-1:0] done_q, done_d;
  logic [SenseLines-1:0] remain, pick, rest;
  logic [SelW-1:0]       sel;
  logic                  adv, emit;
  logic                  out_valid_q;
  logic [DriveW-1:0]     pattern_q;
  logic                  kvalid_q;
  logic [CodeW-1:0]      code_q;
  logic                  last_q;

  assign remain = head_i.press & ~done_q;
  assign adv    = !out_valid_q || out_ready_i;
  assign emit   = adv && head_valid_i;

  always_comb begin
    sel = '0;
    for (int s = SenseLines - 1; s >= 0; s--) begin
      if (remain[s]) begin
        sel = SelW'(s);
      end
    end
    pick = (remain == '0) ? '0 : (SenseLines'(1) << sel);
    rest = remain & ~pick;
  end

  // drop the head once its final word is loaded
  assign pop_o  = emit && (rest == '0);
  assign done_d = pop_o ? '0 : (done_q | pick);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= head_valid_i;
      if (emit) begin
        done_q <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pattern_q <= head_i.drive_pattern;
      kvalid_q  <= (remain != '0);
      code_q    <= (remain != '0) ? head_i.codes[sel] : '0;
      last_q    <= (rest == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_pattern_o = pattern_q;
  assign key_valid_o     = kvalid_q;
  assign key_code_o      = code_q;
  assign last_in_run_o   = last_q;

  a_idle_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !key_valid_o |-> last_in_run_o && (key_code_o == '0))
    else $error("idle word not marked last or carries a code");

  a_done_tracks_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q != '0) |-> head_valid_i && ((done_q & ~head_i.press) == '0))
    else $error("emitted-key mask does not belong to queue head");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !pop_o ##1 $stable(done_q))
    else $error("queue head dropped while output stalled");

  a_pop_with_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (done_q == '0))
    else $error("key mask not cleared after head drop");

endmodule

### rtl/core/matrix_keypad_scanner_top.sv
// Matrix keypad scanner with per-key debounce.
//
// Input channel (in_valid_i / in_ready_o, sense_levels_i): one word per scan
// tick, holding the sense line levels read while the current drive line is low.
// Output channel (out_valid_o / out_ready_i): one word per newly pressed key of
// that tick, in sense line order, or a single word with key_valid_o low when
// nothing was pressed. last_in_run_o marks the final word of a tick, and every
// word carries the drive pattern to apply for the next tick.
// Config channel (cfg_valid_i / cfg_ready_o, key_code_map_i): the sixteen
// 4-bit key codes; always ready, write it only while the block is idle.
// Path: the first word of a tick is registered in the queue, then in the output
// register, before it is presented.
// Throughput: one output word per cycle while out_ready_i is high; the back
// end serializes presses, so a tick yields 1 to 4 words; the front takes a
// tick per cycle while the two-entry queue has room.
// Reset: all keys released with full-high histories, drive line 0 active, map
// at its default. A stalled receiver holds the output word; the queue then
// fills and in_ready_o drops, with no tick lost.
module matrix_keypad_scanner_top import kps_pkg::*; #(
  parameter int unsigned DEBOUNCE_SAMPLES = DebounceSamplesDef,
  parameter int unsigned SCAN_LINES = ScanLinesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        sense_levels_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MapW-1:0]   key_code_map_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DriveW-1:0] drive_pattern_o,
  output logic              key_valid_o,
  output logic [CodeW-1:0]  key_code_o,
  output logic              last_in_run_o
);

  logic [MapW-1:0] map_q;
  logic            push, full, pop, head_valid;
  kps_entry_t      entry, head;

  // the map register accepts a word every cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MapReset;
    end else if (cfg_valid_i) begin
      map_q <= key_code_map_i;
    end
  end

  // front: debounce the active line and classify new presses
  kps_front #(
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
    .SCAN_LINES       (SCAN_LINES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sense_levels_i (sense_levels_i),
    .key_code_map_i (map_q),
    .queue_full_i   (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  // queue: decouple classification from serialization
  kps_fifo #(
    .WIDTH ($bits(kps_entry_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // back: emit one word per press, or an idle word, into the output register
  kps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_pattern_o (drive_pattern_o),
    .key_valid_o     (key_valid_o),
    .key_code_o      (key_code_o),
    .last_in_run_o   (last_in_run_o)
  );

endmodule
